/* src/ecc_pkg.sv */
// ---------------------------------------------------------------------------
// ecc_pkg: shared types and constants for the EtherType class counter
// Item and result layouts, the queued command between the parser and the
// counter bank, counter row layout and protocol constants.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ecc_pkg;

    // Table geometry
    localparam int INTERFACE_SLOTS = 1024;
    localparam int MAX_VLAN_TAGS   = 2;

    localparam int IFIDX_W     = 10;
    localparam int CLASS_COUNT = 4;
    localparam int CNT_W       = 64;
    localparam int LEN_W       = 16;
    localparam int L3_W        = 5;

    // Only interfaces that fit the index field and the table need a row
    localparam int IF_ROWS  = (INTERFACE_SLOTS > (1 << IFIDX_W)) ? (1 << IFIDX_W)
                                                                  : INTERFACE_SLOTS;
    localparam int ROW_W    = $clog2(IF_ROWS);
    localparam int TAG_CNT_W = (MAX_VLAN_TAGS < 2) ? 1 : $clog2(MAX_VLAN_TAGS + 1);

    // Queue depths (powers of two, so pointers wrap on their own)
    localparam int CMDQ_DEPTH = 4;
    localparam int CQ_PTR_W   = $clog2(CMDQ_DEPTH);
    localparam int CQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);
    localparam int RESQ_DEPTH = 4;
    localparam int RQ_PTR_W   = $clog2(RESQ_DEPTH);
    localparam int RQ_CNT_W   = $clog2(RESQ_DEPTH + 1);

    // Protocol constants
    localparam logic [15:0] ET_IPV4 = 16'h0800;
    localparam logic [15:0] ET_IPV6 = 16'h86DD;
    localparam logic [15:0] ET_CTAG = 16'h8100;
    localparam logic [15:0] ET_STAG = 16'h88A8;
    localparam logic [7:0]  NH_ICMPV6   = 8'd58;
    localparam logic [L3_W-1:0] ETH_HDR_LEN = 5'd14;
    localparam logic [L3_W-1:0] TAG_LEN     = 5'd4;
    localparam logic [LEN_W:0]  IPV4_MIN    = 17'd20;
    localparam logic [LEN_W:0]  IPV6_MIN    = 17'd40;
    localparam logic [LEN_W-1:0] NH_OFFSET  = 16'd6;

    // Class codes
    localparam logic [1:0] CLS_IPV4  = 2'd0;
    localparam logic [1:0] CLS_IPV6  = 2'd1;
    localparam logic [1:0] CLS_ICMP6 = 2'd2;
    localparam logic [1:0] CLS_OTHER = 2'd3;

    // Item modes and result kinds
    localparam logic MODE_BYTE  = 1'b0;
    localparam logic MODE_READ  = 1'b1;
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [7:0]         data_byte;
        logic               last_byte;
        logic [IFIDX_W-1:0] interface_index;
        logic [IFIDX_W-1:0] ingress_interface_index;
        logic [1:0]         read_class;
    } t_in_item;

    typedef struct packed {
        logic             result_kind;
        logic [1:0]       frame_class;
        logic             icmpv6_seen;
        logic             interface_counted;
        logic [LEN_W-1:0] frame_length;
        logic [CNT_W-1:0] packet_count;
        logic [CNT_W-1:0] byte_count;
    } t_out_item;

    // Work for the counter bank: a finished frame or a counter read
    typedef struct packed {
        logic               is_read;
        logic [1:0]         cls;     // frame class, or class to read
        logic               icmp;
        logic [IFIDX_W-1:0] ifidx;   // resolved interface, or interface to read
        logic [LEN_W-1:0]   len;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] pkt;
        logic [CNT_W-1:0] byt;
    } t_cnt_entry;

    typedef t_cnt_entry [CLASS_COUNT-1:0] t_row;

    // Interface has its own counters
    function automatic logic if_in_table(input logic [IFIDX_W-1:0] ifidx);
        logic [31:0] wide;
        wide = {{(32-IFIDX_W){1'b0}}, ifidx};
        return (ifidx != '0) && (wide < 32'(INTERFACE_SLOTS));
    endfunction

endpackage

/* src/ecc_parser.sv */
// ---------------------------------------------------------------------------
// ecc_parser: frame byte parser
// Tracks byte position, skips VLAN tags, captures EtherType and IPv6 next
// header, and emits one command per finished frame or per read request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecc_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  ecc_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    output ecc_pkg::t_cmd     o_cmd
);

    logic [ecc_pkg::LEN_W-1:0]     r_pos, n_pos;
    logic [15:0]                   r_et, n_et;
    logic [ecc_pkg::TAG_CNT_W-1:0] r_tags, n_tags;
    logic [ecc_pkg::L3_W-1:0]      r_l3, n_l3;
    logic [7:0]                    r_nh, n_nh;

    logic [ecc_pkg::LEN_W-1:0] l3_cur;
    logic [ecc_pkg::LEN_W:0]   len_x, l3_new_x;
    logic [1:0]                cls;
    logic                      icmp;
    logic                      byte_xfer;

    assign byte_xfer = i_accept && (i_item.mode == ecc_pkg::MODE_BYTE);

    // Advance parse state for one frame byte
    always_comb begin
        l3_cur = {{(ecc_pkg::LEN_W-ecc_pkg::L3_W){1'b0}}, r_l3};
        n_et   = r_et;
        n_tags = r_tags;
        n_l3   = r_l3;
        n_nh   = r_nh;
        if (r_pos == l3_cur - 16'd2) begin
            n_et = {i_item.data_byte, 8'h00};
        end else if (r_pos == l3_cur - 16'd1) begin
            n_et = {r_et[15:8], i_item.data_byte};
            if ((n_et == ecc_pkg::ET_CTAG || n_et == ecc_pkg::ET_STAG) &&
                (r_tags < ecc_pkg::TAG_CNT_W'(ecc_pkg::MAX_VLAN_TAGS))) begin
                n_tags = r_tags + ecc_pkg::TAG_CNT_W'(1);
                n_l3   = r_l3 + ecc_pkg::TAG_LEN;
            end
        end else if (r_pos == l3_cur + ecc_pkg::NH_OFFSET) begin
            n_nh = i_item.data_byte;
        end
        n_pos = (r_pos == '1) ? r_pos : r_pos + 16'd1;
    end

    // Classify on the last byte from the updated state
    always_comb begin
        len_x    = {1'b0, n_pos};
        l3_new_x = {{(ecc_pkg::LEN_W+1-ecc_pkg::L3_W){1'b0}}, n_l3};
        cls      = ecc_pkg::CLS_OTHER;
        icmp     = 1'b0;
        if (len_x >= l3_new_x) begin
            if (n_et == ecc_pkg::ET_IPV4) begin
                if (len_x >= l3_new_x + ecc_pkg::IPV4_MIN) begin
                    cls = ecc_pkg::CLS_IPV4;
                end
            end else if (n_et == ecc_pkg::ET_IPV6) begin
                if (len_x >= l3_new_x + ecc_pkg::IPV6_MIN) begin
                    cls  = ecc_pkg::CLS_IPV6;
                    icmp = (n_nh == ecc_pkg::NH_ICMPV6);
                end
            end
        end
    end

    // Build the command for the back end
    always_comb begin
        o_cmd_valid = i_accept &&
                      ((i_item.mode == ecc_pkg::MODE_READ) || i_item.last_byte);
        if (i_item.mode == ecc_pkg::MODE_READ) begin
            o_cmd.is_read = 1'b1;
            o_cmd.cls     = i_item.read_class;
            o_cmd.icmp    = 1'b0;
            o_cmd.ifidx   = i_item.interface_index;
            o_cmd.len     = '0;
        end else begin
            o_cmd.is_read = 1'b0;
            o_cmd.cls     = cls;
            o_cmd.icmp    = icmp;
            o_cmd.ifidx   = (i_item.interface_index != '0) ? i_item.interface_index
                                                          : i_item.ingress_interface_index;
            o_cmd.len     = n_pos;
        end
    end

    // Hold parse state; restart it after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_et   <= '0;
            r_tags <= '0;
            r_l3   <= ecc_pkg::ETH_HDR_LEN;
            r_nh   <= '0;
        end else if (byte_xfer) begin
            if (i_item.last_byte) begin
                r_pos  <= '0;
                r_et   <= '0;
                r_tags <= '0;
                r_l3   <= ecc_pkg::ETH_HDR_LEN;
                r_nh   <= '0;
            end else begin
                r_pos  <= n_pos;
                r_et   <= n_et;
                r_tags <= n_tags;
                r_l3   <= n_l3;
                r_nh   <= n_nh;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // L3 offset always matches the number of tags skipped
    a_l3_tracks_tags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_l3 == ecc_pkg::ETH_HDR_LEN + ecc_pkg::L3_W'(r_tags) * ecc_pkg::TAG_LEN)
        else $error("l3 offset out of step with tag count");
`endif

endmodule

/* src/ecc_cmd_queue.sv */
// ---------------------------------------------------------------------------
// ecc_cmd_queue: command queue between parser and counter bank
// Small register FIFO that lets the front and back ends stall on their own.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecc_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ecc_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output ecc_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    ecc_pkg::t_cmd                r_q [ecc_pkg::CMDQ_DEPTH];
    logic [ecc_pkg::CQ_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [ecc_pkg::CQ_CNT_W-1:0] r_count;
    logic                         do_pop;

    assign o_full  = (r_count == ecc_pkg::CQ_CNT_W'(ecc_pkg::CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_q[r_rd_ptr];
    assign do_pop  = i_pop && !o_empty;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + ecc_pkg::CQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + ecc_pkg::CQ_PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + ecc_pkg::CQ_CNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - ecc_pkg::CQ_CNT_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    // Never write into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < ecc_pkg::CQ_CNT_W'(ecc_pkg::CMDQ_DEPTH)))
        else $error("command queue overflow");
`endif

endmodule

/* src/ecc_counter_bank.sv */
// ---------------------------------------------------------------------------
// ecc_counter_bank: counter back end
// Read-modify-write of per-interface counter rows and global counters,
// counter reads, a result queue, and the clearing pass after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecc_counter_bank (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ecc_pkg::t_cmd      i_cmd,
    input  logic               i_cmd_empty,
    output logic               o_cmd_pop,
    output logic               o_clearing,
    input  logic               i_pop,
    output logic               o_empty,
    output ecc_pkg::t_out_item o_result
);

    // Interface counter memory, one row of four classes per interface
    ecc_pkg::t_row r_mem [ecc_pkg::IF_ROWS];
    ecc_pkg::t_row r_rdata;

    ecc_pkg::t_cnt_entry r_glob [ecc_pkg::CLASS_COUNT];
    ecc_pkg::t_cnt_entry b_new_glob [ecc_pkg::CLASS_COUNT];

    logic                      r_clr_active;
    logic [ecc_pkg::ROW_W-1:0] r_clr_row;

    logic          r_b_valid;
    ecc_pkg::t_cmd r_b_cmd;

    logic                      r_byp_valid;
    logic [ecc_pkg::ROW_W-1:0] r_byp_row;
    ecc_pkg::t_row             r_byp_data;

    ecc_pkg::t_out_item           r_rq [ecc_pkg::RESQ_DEPTH];
    logic [ecc_pkg::RQ_PTR_W-1:0] r_rq_wr, r_rq_rd;
    logic [ecc_pkg::RQ_CNT_W-1:0] r_rq_count;

    logic                      issue;
    logic [ecc_pkg::ROW_W-1:0] issue_row, b_row_idx, mem_wa;
    logic                      b_counted, b_wr, mem_we, rq_pop;
    ecc_pkg::t_row             b_row, b_new_row, mem_wd;
    ecc_pkg::t_cnt_entry       b_read_entry;
    ecc_pkg::t_out_item        b_result;

    // Issue a command when the result queue has room for everything in flight
    assign issue = !i_cmd_empty && !r_clr_active &&
                   ((r_rq_count + ecc_pkg::RQ_CNT_W'(r_b_valid)) <
                    ecc_pkg::RQ_CNT_W'(ecc_pkg::RESQ_DEPTH));
    assign o_cmd_pop  = issue;
    assign o_clearing = r_clr_active;
    assign issue_row  = i_cmd.ifidx[ecc_pkg::ROW_W-1:0];
    assign b_row_idx  = r_b_cmd.ifidx[ecc_pkg::ROW_W-1:0];

    // Update stage: forward last write, add, build result
    always_comb begin
        b_counted = ecc_pkg::if_in_table(r_b_cmd.ifidx);
        b_row     = (r_byp_valid && (r_byp_row == b_row_idx)) ? r_byp_data : r_rdata;
        for (int c = 0; c < ecc_pkg::CLASS_COUNT; c++) begin
            logic hit;
            hit = (2'(c) == r_b_cmd.cls) ||
                  (r_b_cmd.icmp && (2'(c) == ecc_pkg::CLS_ICMP6));
            b_new_row[c].pkt  = b_row[c].pkt + ecc_pkg::CNT_W'(hit);
            b_new_row[c].byt  = b_row[c].byt + (hit ? ecc_pkg::CNT_W'(r_b_cmd.len)
                                                    : '0);
            b_new_glob[c].pkt = r_glob[c].pkt + ecc_pkg::CNT_W'(hit);
            b_new_glob[c].byt = r_glob[c].byt + (hit ? ecc_pkg::CNT_W'(r_b_cmd.len)
                                                     : '0);
        end
        b_wr = r_b_valid && !r_b_cmd.is_read && b_counted;

        if (r_b_cmd.ifidx == '0) begin
            b_read_entry = r_glob[r_b_cmd.cls];
        end else if (b_counted) begin
            b_read_entry = b_row[r_b_cmd.cls];
        end else begin
            b_read_entry = '0;
        end

        b_result = '0;
        if (r_b_cmd.is_read) begin
            b_result.result_kind  = ecc_pkg::KIND_READ;
            b_result.packet_count = b_read_entry.pkt;
            b_result.byte_count   = b_read_entry.byt;
        end else begin
            b_result.result_kind       = ecc_pkg::KIND_FRAME;
            b_result.frame_class       = r_b_cmd.cls;
            b_result.icmpv6_seen       = r_b_cmd.icmp;
            b_result.interface_counted = b_counted;
            b_result.frame_length      = r_b_cmd.len;
        end
    end

    // Select memory write: clearing pass or counter update
    always_comb begin
        mem_we = r_clr_active || b_wr;
        mem_wa = r_clr_active ? r_clr_row : b_row_idx;
        mem_wd = r_clr_active ? '0 : b_new_row;
    end

    // Counter memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (issue) begin
            r_rdata <= r_mem[issue_row];
        end
    end

    // Hold the command in the update stage and the bypass payload
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_b_cmd <= i_cmd;
        end
        if (b_wr) begin
            r_byp_row  <= b_row_idx;
            r_byp_data <= b_new_row;
        end
    end

    // Control: clearing pass, stage valid, bypass valid, global counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_row    <= '0;
            r_b_valid    <= 1'b0;
            r_byp_valid  <= 1'b0;
            for (int c = 0; c < ecc_pkg::CLASS_COUNT; c++) begin
                r_glob[c] <= '0;
            end
        end else begin
            if (r_clr_active) begin
                r_clr_row <= r_clr_row + ecc_pkg::ROW_W'(1);
                if (r_clr_row == ecc_pkg::ROW_W'(ecc_pkg::IF_ROWS - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end
            r_b_valid   <= issue;
            r_byp_valid <= b_wr;
            if (r_b_valid && !r_b_cmd.is_read) begin
                for (int c = 0; c < ecc_pkg::CLASS_COUNT; c++) begin
                    r_glob[c] <= b_new_glob[c];
                end
            end
        end
    end

    // Result queue
    assign o_empty  = (r_rq_count == '0);
    assign o_result = r_rq[r_rq_rd];
    assign rq_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_rq[r_rq_wr] <= b_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rq_wr    <= '0;
            r_rq_rd    <= '0;
            r_rq_count <= '0;
        end else begin
            if (r_b_valid) begin
                r_rq_wr <= r_rq_wr + ecc_pkg::RQ_PTR_W'(1);
            end
            if (rq_pop) begin
                r_rq_rd <= r_rq_rd + ecc_pkg::RQ_PTR_W'(1);
            end
            if (r_b_valid && !rq_pop) begin
                r_rq_count <= r_rq_count + ecc_pkg::RQ_CNT_W'(1);
            end else if (!r_b_valid && rq_pop) begin
                r_rq_count <= r_rq_count - ecc_pkg::RQ_CNT_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    // Credit check keeps room for every result in flight
    a_rq_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_rq_count < ecc_pkg::RQ_CNT_W'(ecc_pkg::RESQ_DEPTH)))
        else $error("result queue overflow");

    // No command reaches the update stage during the clearing pass
    a_no_work_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !r_b_valid)
        else $error("command issued during clearing pass");

    // Counter updates never touch the unused row of interface zero
    a_no_row_zero_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_wr |-> (r_b_cmd.ifidx != '0))
        else $error("counter update for interface zero");
`endif

endmodule

/* src/ethertype_class_counter.sv */
// ---------------------------------------------------------------------------
// ethertype_class_counter: Ethernet EtherType classifier with class counters
// Path: a frame's last byte or a read request goes into the command queue,
//   then to the update stage, and its result into the result queue.
// Throughput: one item per cycle while full is low, set by the counter row
//   read-modify-write in the back end, which reads and writes a row each
//   cycle and forwards its last write.
// Reset: synchronous; the interface counter memory is then cleared one row
//   per cycle, all 1024 rows, with full held high during that pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ethertype_class_counter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  ecc_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output ecc_pkg::t_out_item o_result
);

    logic          accept;
    logic          cmd_valid, cmdq_full, cmdq_empty, cmd_pop, clearing;
    ecc_pkg::t_cmd cmd_in, cmd_head;

    // Refuse items while the queue is full or the counters are being cleared
    assign full   = cmdq_full || clearing;
    assign accept = push && !full;

    ecc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd_in)
    );

    ecc_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_cmd   (cmd_in),
        .o_full  (cmdq_full),
        .i_pop   (cmd_pop),
        .o_cmd   (cmd_head),
        .o_empty (cmdq_empty)
    );

    ecc_counter_bank u_bank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_head),
        .i_cmd_empty (cmdq_empty),
        .o_cmd_pop   (cmd_pop),
        .o_clearing  (clearing),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

/* dv/ecc_class_checker.sv */
// ---------------------------------------------------------------------------
// ecc_class_checker: result predictor and comparator for the class counter
// Watches the item and result queues of ethertype_class_counter, parses each
// transferred frame byte the way the block should, keeps its own counter
// bank, and compares every popped result field by field with the oldest
// outstanding prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecc_class_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_full,
    input  ecc_pkg::t_in_item i_item,
    input  logic              i_empty,
    input  logic              i_pop,
    input  ecc_pkg::t_out_item i_result,
    output int                o_errors,
    output int                o_pending,
    output int                o_frames,
    output int                o_reads,
    output int                o_icmp6_frames,
    output int                o_longest
);
    import ecc_pkg::*;

    // Frame parse state
    logic [LEN_W-1:0] byte_pos;
    logic [15:0]      ethertype;
    int               tag_count;
    int               l3_offset;
    logic [7:0]       next_hdr;

    // Counter bank
    logic [CNT_W-1:0] glob_pkts  [CLASS_COUNT];
    logic [CNT_W-1:0] glob_bytes [CLASS_COUNT];
    logic [CNT_W-1:0] if_pkts    [INTERFACE_SLOTS][CLASS_COUNT];
    logic [CNT_W-1:0] if_bytes   [INTERFACE_SLOTS][CLASS_COUNT];

    t_out_item awaited_results [$];
    int errors;
    int frames;
    int reads;
    int icmp6_frames;
    int longest;

    // Add one frame to the global and, if it has a row, the interface counters
    function automatic logic count_frame(input logic [IFIDX_W-1:0] ifidx,
                                         input logic [1:0] cls,
                                         input logic [LEN_W-1:0] len);
        glob_pkts[cls]  += 64'd1;
        glob_bytes[cls] += CNT_W'(len);
        if (ifidx != '0 && int'(ifidx) < INTERFACE_SLOTS) begin
            if_pkts[ifidx][cls]  += 64'd1;
            if_bytes[ifidx][cls] += CNT_W'(len);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    task automatic clear_parse();
        byte_pos  = '0;
        ethertype = '0;
        tag_count = 0;
        l3_offset = int'(ETH_HDR_LEN);
        next_hdr  = '0;
    endtask

    // Advance the parse by one transferred item and queue the result it causes
    task automatic parse_and_count(input t_in_item it);
        t_out_item        want;
        int               pos;
        logic [1:0]       cls;
        logic             icmp;
        logic             counted;
        logic [LEN_W-1:0] len;
        logic [IFIDX_W-1:0] ifidx;
        want = '0;
        if (it.mode == MODE_READ) begin
            want.result_kind = KIND_READ;
            if (it.interface_index == '0) begin
                want.packet_count = glob_pkts[it.read_class];
                want.byte_count   = glob_bytes[it.read_class];
            end else if (int'(it.interface_index) < INTERFACE_SLOTS) begin
                want.packet_count = if_pkts[it.interface_index][it.read_class];
                want.byte_count   = if_bytes[it.interface_index][it.read_class];
            end
            awaited_results.push_back(want);
            reads++;
            return;
        end

        // Capture EtherType bytes, skip tags, pick up the next header byte
        pos = int'(byte_pos);
        if (pos == l3_offset - 2) begin
            ethertype = {it.data_byte, 8'h00};
        end else if (pos == l3_offset - 1) begin
            ethertype[7:0] = it.data_byte;
            if ((ethertype == ET_CTAG || ethertype == ET_STAG) &&
                tag_count < MAX_VLAN_TAGS) begin
                tag_count++;
                l3_offset += int'(TAG_LEN);
            end
        end else if (pos == l3_offset + int'(NH_OFFSET)) begin
            next_hdr = it.data_byte;
        end
        if (byte_pos != '1)
            byte_pos++;
        if (!it.last_byte)
            return;

        // Classify on the last byte
        len  = byte_pos;
        cls  = CLS_OTHER;
        icmp = 1'b0;
        if (int'(len) >= l3_offset) begin
            if (ethertype == ET_IPV4 && int'(len) >= l3_offset + int'(IPV4_MIN)) begin
                cls = CLS_IPV4;
            end else if (ethertype == ET_IPV6 &&
                         int'(len) >= l3_offset + int'(IPV6_MIN)) begin
                cls  = CLS_IPV6;
                icmp = (next_hdr == NH_ICMPV6);
            end
        end
        ifidx   = (it.interface_index != '0) ? it.interface_index
                                             : it.ingress_interface_index;
        counted = count_frame(ifidx, cls, len);
        if (icmp)
            void'(count_frame(ifidx, CLS_ICMP6, len));

        want.result_kind       = KIND_FRAME;
        want.frame_class       = cls;
        want.icmpv6_seen       = icmp;
        want.interface_counted = counted;
        want.frame_length      = len;
        awaited_results.push_back(want);
        frames++;
        if (icmp)
            icmp6_frames++;
        if (int'(len) > longest)
            longest = int'(len);
        clear_parse();
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            clear_parse();
            for (int c = 0; c < CLASS_COUNT; c++) begin
                glob_pkts[c]  = '0;
                glob_bytes[c] = '0;
            end
            for (int s = 0; s < INTERFACE_SLOTS; s++) begin
                for (int c = 0; c < CLASS_COUNT; c++) begin
                    if_pkts[s][c]  = '0;
                    if_bytes[s][c] = '0;
                end
            end
            awaited_results.delete();
        end else begin
            // Compare a popped result with the oldest prediction
            if (i_pop && !i_empty) begin
                if (awaited_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, i_result);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("result_kind", 64'(want.result_kind),
                                64'(i_result.result_kind));
                    check_field("frame_class", 64'(want.frame_class),
                                64'(i_result.frame_class));
                    check_field("icmpv6_seen", 64'(want.icmpv6_seen),
                                64'(i_result.icmpv6_seen));
                    check_field("interface_counted", 64'(want.interface_counted),
                                64'(i_result.interface_counted));
                    check_field("frame_length", 64'(want.frame_length),
                                64'(i_result.frame_length));
                    check_field("packet_count", want.packet_count, i_result.packet_count);
                    check_field("byte_count", want.byte_count, i_result.byte_count);
                end
            end
            if (i_push && !i_full)
                parse_and_count(i_item);
        end
        o_errors       <= errors;
        o_pending      <= awaited_results.size();
        o_frames       <= frames;
        o_reads        <= reads;
        o_icmp6_frames <= icmp6_frames;
        o_longest      <= longest;
    end

endmodule

/* dv/tb.sv */
// ---------------------------------------------------------------------------
// tb: stimulus and verdict for ethertype_class_counter
// Sends directed frames (tag skipping, truncation, class thresholds, ICMPv6,
// interface fallback, length saturation) and counter reads, then a random
// mix of well-formed frames, broken frames and reads, with random gaps on
// the item side and random stalls on the result side.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import ecc_pkg::*;

    typedef logic [7:0] t_byte_q [$];

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1250;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    logic      pop   = 1'b0;
    t_in_item  item  = '0;
    logic      full;
    logic      empty;
    t_out_item result;

    int errors;
    int pending;
    int frames;
    int reads;
    int icmp6_frames;
    int longest;

    int cycles   = 0;
    int n_items  = 0;
    int rx_stall = 0;
    bit rx_calm  = 1'b0;
    bit tx_calm  = 1'b0;

    ethertype_class_counter dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .push     (push),
        .full     (full),
        .i_item   (item),
        .empty    (empty),
        .pop      (pop),
        .o_result (result)
    );

    ecc_class_checker chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_item         (item),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_result       (result),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_frames       (frames),
        .o_reads        (reads),
        .o_icmp6_frames (icmp6_frames),
        .o_longest      (longest)
    );

    always #5 clk = ~clk;

    // Bound the run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Mostly short idle stretches, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: pop, with random stalls unless told to drain freely
    always @(posedge clk) begin
        if (rx_calm) begin
            pop <= 1'b1;
        end else if (rx_stall > 0) begin
            pop      <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 99) < 20)
                rx_stall <= idle_length();
        end
    end

    // Small pool of interfaces so reads find nonzero counters
    function automatic logic [IFIDX_W-1:0] pick_interface();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return '0;
        if (r < 75) begin
            case ($urandom_range(0, 3))
                0: return IFIDX_W'(1);
                1: return IFIDX_W'(2);
                2: return IFIDX_W'(3);
                default: return '1;
            endcase
        end
        return IFIDX_W'($urandom);
    endfunction

    // Build a frame: addresses, tags, EtherType, then the L3 bytes
    function automatic t_byte_q make_frame(input int ntags, input logic [15:0] etype,
                                           input int l3_len, input logic [7:0] nh);
        t_byte_q     f;
        logic [15:0] tpid;
        repeat (12) f.push_back(8'($urandom));
        repeat (ntags) begin
            tpid = $urandom_range(0, 1) ? ET_CTAG : ET_STAG;
            f.push_back(tpid[15:8]);
            f.push_back(tpid[7:0]);
            f.push_back(8'($urandom));
            f.push_back(8'($urandom));
        end
        f.push_back(etype[15:8]);
        f.push_back(etype[7:0]);
        for (int i = 0; i < l3_len; i++)
            f.push_back((i == int'(NH_OFFSET)) ? nh : 8'($urandom));
        return f;
    endfunction

    function automatic t_byte_q cut_frame(input t_byte_q f, input int n);
        while (f.size() > n)
            void'(f.pop_back());
        return f;
    endfunction

    // Hold the item until the block takes it, then idle for a random gap
    task automatic send_item(input t_in_item it);
        int gap;
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        n_items++;
        if (!tx_calm) begin
            gap = idle_length();
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_read(input logic [IFIDX_W-1:0] ifidx, input logic [1:0] cls);
        t_in_item it;
        it                 = $urandom;
        it.mode            = MODE_READ;
        it.interface_index = ifidx;
        it.read_class      = cls;
        send_item(it);
    endtask

    // Send frame bytes; interfaces only matter on the last byte
    task automatic send_frame(input t_byte_q f, input logic [IFIDX_W-1:0] prim,
                              input logic [IFIDX_W-1:0] ingr, input bit mid_read);
        t_in_item it;
        for (int i = 0; i < f.size(); i++) begin
            if (mid_read && i == f.size() / 2)
                send_read(pick_interface(), 2'($urandom));
            it           = $urandom;
            it.mode      = MODE_BYTE;
            it.data_byte = f[i];
            it.last_byte = (i == f.size() - 1);
            if (it.last_byte) begin
                it.interface_index         = prim;
                it.ingress_interface_index = ingr;
            end
            send_item(it);
        end
    endtask

    // Hold off the sender until every outstanding result has been popped
    task automatic wait_for_results();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    initial begin
        t_byte_q     f;
        logic [15:0] etype;
        int          start;
        int          done;
        int          next_drain;
        int          r;
        int          l3_len;
        int          drain_cycles;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reads of the cleared global counters
        for (int c = 0; c < CLASS_COUNT; c++)
            send_read('0, 2'(c));

        // Class thresholds for IPv4 and IPv6, ICMPv6 next header
        send_frame(make_frame(0, ET_IPV4, 20, 8'h00), IFIDX_W'(1), '0, 1'b0);
        send_frame(make_frame(0, ET_IPV4, 19, 8'h00), IFIDX_W'(1), '0, 1'b0);
        send_frame(make_frame(0, ET_IPV6, 40, NH_ICMPV6), '0, IFIDX_W'(2), 1'b0);
        send_frame(make_frame(0, ET_IPV6, 39, NH_ICMPV6), '0, IFIDX_W'(2), 1'b0);
        send_frame(make_frame(0, ET_IPV6, 40, 8'd6), '1, IFIDX_W'(5), 1'b0);

        // Tag skipping, too many tags, no interface, read in mid-frame
        send_frame(make_frame(1, ET_IPV4, 24, 8'h00), IFIDX_W'(3), '0, 1'b1);
        send_frame(make_frame(2, ET_IPV6, 48, NH_ICMPV6), '0, '0, 1'b0);
        send_frame(make_frame(3, ET_IPV4, 30, 8'h00), IFIDX_W'(2), '0, 1'b0);

        // Truncated inside the Ethernet header and right after a tag
        send_frame(cut_frame(make_frame(0, ET_IPV4, 20, 8'h00), 1), IFIDX_W'(1), '0, 1'b0);
        send_frame(cut_frame(make_frame(0, ET_IPV4, 20, 8'h00), 13), IFIDX_W'(1), '0, 1'b0);
        send_frame(cut_frame(make_frame(1, ET_IPV4, 20, 8'h00), 16), '0, '1, 1'b0);

        // Unknown EtherType
        send_frame(make_frame(0, 16'h1234, 46, 8'h00), '1, '0, 1'b0);

        // Length saturation: one long frame sent back to back
        tx_calm = 1'b1;
        send_frame(make_frame(0, ET_IPV4, 65600 - 14, 8'h00), IFIDX_W'(1), '0, 1'b0);
        tx_calm = 1'b0;

        // Read back every class for the global counters and interfaces 1, 2, 5 and 1023
        for (int c = 0; c < CLASS_COUNT; c++) begin
            send_read('0, 2'(c));
            send_read(IFIDX_W'(1), 2'(c));
            send_read(IFIDX_W'(2), 2'(c));
            send_read(IFIDX_W'(5), 2'(c));
            send_read('1, 2'(c));
        end
        wait_for_results();

        // Random mix: mostly well-formed frames, some broken ones, reads
        start      = n_items;
        next_drain = 300;
        while (n_items - start < RANDOM_ITEMS) begin
            done    = n_items - start;
            tx_calm = (done >= 500 && done < 700);
            rx_calm <= (done >= 500 && done < 700);
            if (done >= next_drain) begin
                wait_for_results();
                next_drain += 300;
            end
            r = $urandom_range(0, 99);
            if (r < 15) begin
                send_read(pick_interface(), 2'($urandom));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    etype = ET_IPV4;
                else if (r < 80)
                    etype = ET_IPV6;
                else if (r < 90)
                    etype = 16'($urandom);
                else
                    etype = $urandom_range(0, 1) ? ET_CTAG : ET_STAG;
                if ($urandom_range(0, 99) < 60)
                    l3_len = ((etype == ET_IPV6) ? 40 : 20) + $urandom_range(0, 8) - 2;
                else
                    l3_len = $urandom_range(0, 70);
                f = make_frame($urandom_range(0, 99) < 55 ? 0 : $urandom_range(1, 3),
                               etype, l3_len,
                               $urandom_range(0, 1) ? NH_ICMPV6 : 8'($urandom));
                // Broken frame: cut short at a random point
                if ($urandom_range(0, 99) < 25)
                    f = cut_frame(f, $urandom_range(1, f.size()));
                send_frame(f, pick_interface(), pick_interface(),
                           $urandom_range(0, 9) == 0);
            end
        end

        // Drain, then let the pipeline run dry
        push    <= 1'b0;
        rx_calm <= 1'b1;
        @(posedge clk);
        drain_cycles = 0;
        while (pending != 0 && drain_cycles < 5000) begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (20) @(posedge clk);

        if (pending != 0)
            $display("%0t: results missing, expected %0d more, got none", $time, pending);
        $display("Covered %0d frames (%0d ICMPv6, longest %0d bytes) and %0d counter reads,",
                 frames, icmp6_frames, longest, reads);
        $display("in %0d transferred items over %0d cycles.", n_items, cycles);
        if (errors == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
